// File: rtl/gsa_pkg.sv
package gsa_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = IDX_W + 1;
  localparam int GEN_W      = 32;
  localparam int REPO_W     = 8;

  localparam logic [GEN_W-1:0] GEN_INIT = GEN_W'(1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // free stack entry keeps the generation so a pop needs no slot table read
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } stk_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef struct packed {
    logic             alive;
    logic [GEN_W-1:0] gen;
  } slot_entry_t;

endpackage

// File: rtl/gsa_free_stack.sv
module gsa_free_stack (
  input  logic                  clk,
  input  logic                  rst,
  input  gsa_pkg::stk_ctl_t     ctl,
  input  gsa_pkg::stk_entry_t   push_data,
  output gsa_pkg::stk_entry_t   top,
  output logic [gsa_pkg::CNT_W-1:0] count
);
  import gsa_pkg::*;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOT_COUNT);

  stk_entry_t       mem [SLOT_COUNT];
  logic [CNT_W-1:0] fc;
  logic [CNT_W-1:0] fc_next;
  logic             push_en;
  logic [IDX_W-1:0] push_addr;
  logic [IDX_W-1:0] rd_addr;
  stk_entry_t       rd_q;
  logic             fwd;
  stk_entry_t       fwd_data;

  // a push onto a full stack is dropped
  assign push_en   = ctl.push && (fc != FULL_COUNT);
  assign push_addr = fc[IDX_W-1:0];

  always_comb begin
    fc_next = fc;
    if (push_en) begin
      fc_next = fc + CNT_W'(1);
    end else if (ctl.pop) begin
      fc_next = fc - CNT_W'(1);
    end
  end

  // always prefetch the entry that will be on top after this edge
  assign rd_addr = IDX_W'(fc_next - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[push_addr] <= push_data;
    end
    rd_q     <= mem[rd_addr];
    fwd      <= push_en && (push_addr == rd_addr);
    fwd_data <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fc <= '0;
    end else begin
      fc <= fc_next;
    end
  end

  assign top   = fwd ? fwd_data : rd_q;
  assign count = fc;

endmodule

// File: rtl/generational_slot_allocator.sv
// channel   direction  signals                                            handshake
// request   in         operation handle_repo handle_index handle_generation start / busy
// result    out        status out_repo out_index out_generation           done strobe
// config    in         cfg_data (repo_id)                                 cfg_valid / cfg_ready
//
// a request accepted at one edge is checked against the slot table and free stack in the
// next cycle; its result is registered from that check and shown with done for one cycle,
// and a new request is taken every cycle while busy is low.
// slot table and free stack reads are prefetched at accept time and bypassed on collisions.
// rst is synchronous; busy stays high for one cycle after reset is released.
// slots at or above the high-water mark read as never used, so no clearing pass is needed.
// the receiver cannot stall; done is never held off.
module generational_slot_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [gsa_pkg::REPO_W-1:0]   handle_repo,
  input  logic [gsa_pkg::IDX_W-1:0]    handle_index,
  input  logic [gsa_pkg::GEN_W-1:0]    handle_generation,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [gsa_pkg::REPO_W-1:0]   out_repo,
  output logic [gsa_pkg::IDX_W-1:0]    out_index,
  output logic [gsa_pkg::GEN_W-1:0]    out_generation,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gsa_pkg::REPO_W-1:0]   cfg_data
);
  import gsa_pkg::*;

  localparam logic [CNT_W-1:0] MARK_LIMIT = CNT_W'(SLOT_COUNT);

  logic              busy_q;
  logic              accept;
  logic [REPO_W-1:0] repo_id;
  logic [CNT_W-1:0]  mark;
  logic [CNT_W-1:0]  mark_next;

  // request stage
  logic              v1;
  op_t               op1;
  logic [REPO_W-1:0] hrepo1;
  logic [IDX_W-1:0]  hidx1;
  logic [GEN_W-1:0]  hgen1;

  // slot table
  slot_entry_t       slot_mem [SLOT_COUNT];
  slot_entry_t       slot_rd_q;
  logic              slot_fwd;
  slot_entry_t       slot_fwd_data;
  slot_entry_t       slot_cur;
  logic              slot_we;
  logic [IDX_W-1:0]  slot_wa;
  slot_entry_t       slot_wd;

  // free stack
  stk_ctl_t          stk_ctl;
  stk_entry_t        stk_push;
  stk_entry_t        stk_top;
  logic [CNT_W-1:0]  stk_count;

  // result
  status_t           r_status;
  logic [REPO_W-1:0] r_repo;
  logic [IDX_W-1:0]  r_idx;
  logic [GEN_W-1:0]  r_gen;
  logic [GEN_W-1:0]  gen_bump;
  logic              handle_ok;
  status_t           status_q;

  assign busy      = busy_q;
  assign accept    = start && !busy_q;
  assign cfg_ready = !busy_q;
  assign status    = status_q;

  gsa_free_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (stk_ctl),
    .push_data (stk_push),
    .top       (stk_top),
    .count     (stk_count)
  );

  assign slot_cur = slot_fwd ? slot_fwd_data : slot_rd_q;
  assign gen_bump = (slot_cur.gen == {GEN_W{1'b1}}) ? GEN_INIT : slot_cur.gen + GEN_W'(1);

  assign handle_ok = (repo_id != '0) && (hrepo1 == repo_id) && (hidx1 != '0) &&
                     ({1'b0, hidx1} < mark) && slot_cur.alive && (slot_cur.gen == hgen1);

  always_comb begin
    r_status  = ST_OK;
    r_repo    = repo_id;
    r_idx     = hidx1;
    r_gen     = gen_bump;
    mark_next = mark;
    slot_we   = 1'b0;
    slot_wa   = hidx1;
    slot_wd   = '{alive: 1'b0, gen: gen_bump};
    stk_ctl   = '0;
    stk_push  = '{idx: hidx1, gen: gen_bump};
    case (op1)
      OP_ALLOC: begin
        if (stk_count != '0) begin
          r_idx       = stk_top.idx;
          r_gen       = stk_top.gen;
          stk_ctl.pop = v1;
        end else if (mark != MARK_LIMIT) begin
          // first use of a slot, its generation is the reset value
          r_idx     = mark[IDX_W-1:0];
          r_gen     = GEN_INIT;
          mark_next = v1 ? mark + CNT_W'(1) : mark;
        end else begin
          r_status = ST_FULL;
        end
        slot_we = v1 && (r_status == ST_OK);
        slot_wa = r_idx;
        slot_wd = '{alive: 1'b1, gen: r_gen};
      end
      OP_RELEASE: begin
        if (handle_ok) begin
          slot_we      = v1;
          stk_ctl.push = v1;
        end else begin
          r_status = ST_INVALID;
        end
      end
      default: begin
        r_status = ST_INVALID;
      end
    endcase
    if (r_status != ST_OK) begin
      r_repo = '0;
      r_idx  = '0;
      r_gen  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q     <= slot_mem[handle_index];
    slot_fwd      <= slot_we && (slot_wa == handle_index);
    slot_fwd_data <= slot_wd;
  end

  always_ff @(posedge clk) begin
    op1            <= op_t'(operation);
    hrepo1         <= handle_repo;
    hidx1          <= handle_index;
    hgen1          <= handle_generation;
    status_q       <= r_status;
    out_repo       <= r_repo;
    out_index      <= r_idx;
    out_generation <= r_gen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q  <= 1'b1;
      v1      <= 1'b0;
      done    <= 1'b0;
      mark    <= CNT_W'(1);
      repo_id <= REPO_W'(1);
    end else begin
      busy_q <= 1'b0;
      v1     <= accept;
      done   <= v1;
      mark   <= mark_next;
      if (cfg_valid && cfg_ready) begin
        repo_id <= cfg_data;
      end
    end
  end

endmodule

// File: tb/tb_generational_slot_allocator.sv
`timescale 1ns / 1ps

module tb_generational_slot_allocator;
  import gsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    status_t           status;
    logic [REPO_W-1:0] repo;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  gen;
  } slot_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [REPO_W-1:0] cfg_val;
    op_t               op;
    logic [REPO_W-1:0] hrepo;
    logic [IDX_W-1:0]  hidx;
    logic [GEN_W-1:0]  hgen;
    logic              typed;
    slot_result_t      want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              operation = 1'b0;
  logic [REPO_W-1:0] handle_repo = '0;
  logic [IDX_W-1:0]  handle_index = '0;
  logic [GEN_W-1:0]  handle_generation = '0;
  logic              done;
  logic [1:0]        status;
  logic [REPO_W-1:0] out_repo;
  logic [IDX_W-1:0]  out_index;
  logic [GEN_W-1:0]  out_generation;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [REPO_W-1:0] cfg_data = '0;

  generational_slot_allocator dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .operation         (operation),
    .handle_repo       (handle_repo),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .done              (done),
    .status            (status),
    .out_repo          (out_repo),
    .out_index         (out_index),
    .out_generation    (out_generation),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the slot table
  logic [REPO_W-1:0] cur_repo;
  bit                alive_tab [SLOT_COUNT];
  logic [GEN_W-1:0]  gen_tab [SLOT_COUNT];
  logic [IDX_W-1:0]  free_stk [SLOT_COUNT];
  int                free_cnt;
  int                next_fresh;

  slot_result_t      pending_q [$];
  logic [IDX_W-1:0]  live_q [$];
  plan_row_t         plan [$];

  int n_items, n_alloc_ok, n_release_ok, n_rejected, n_full, n_cfg;
  int n_bad;
  int burst_left;
  int stall_cycles;

  function automatic slot_result_t predict_slot(op_t op, logic [REPO_W-1:0] hrepo,
                                                logic [IDX_W-1:0] hidx,
                                                logic [GEN_W-1:0] hgen);
    slot_result_t r;
    logic [IDX_W-1:0] ix;
    logic [GEN_W-1:0] nxt;
    r = '0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      if (free_cnt > 0) begin
        free_cnt--;
        ix = free_stk[free_cnt];
      end else if (next_fresh < SLOT_COUNT) begin
        ix = next_fresh[IDX_W-1:0];
        next_fresh++;
      end else begin
        r.status = ST_FULL;
        return r;
      end
      alive_tab[ix] = 1'b1;
      r.repo = cur_repo;
      r.idx  = ix;
      r.gen  = gen_tab[ix];
    end else if (cur_repo == 0 || hrepo != cur_repo || hidx == 0 || hidx >= next_fresh ||
                 !alive_tab[hidx] || gen_tab[hidx] != hgen) begin
      r.status = ST_INVALID;
    end else begin
      nxt = gen_tab[hidx] + 1;
      if (nxt == 0) nxt = 1;
      gen_tab[hidx]   = nxt;
      alive_tab[hidx] = 1'b0;
      if (free_cnt < SLOT_COUNT) begin
        free_stk[free_cnt] = hidx;
        free_cnt++;
      end
      r.repo = cur_repo;
      r.idx  = hidx;
      r.gen  = nxt;
    end
    return r;
  endfunction

  task automatic req_row(input op_t op, input logic [REPO_W-1:0] hr, input logic [IDX_W-1:0] hi,
                         input logic [GEN_W-1:0] hg, input logic typed, input status_t st,
                         input logic [REPO_W-1:0] r, input logic [IDX_W-1:0] i,
                         input logic [GEN_W-1:0] g);
    plan_row_t row;
    row = '0;
    row.op = op;
    row.hrepo = hr;
    row.hidx = hi;
    row.hgen = hg;
    row.typed = typed;
    row.want.status = st;
    row.want.repo = r;
    row.want.idx = i;
    row.want.gen = g;
    plan.insert(plan.size(), row);
  endtask

  task automatic cfg_row(input logic [REPO_W-1:0] v);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    plan.insert(plan.size(), row);
  endtask

  // only while idle: drain, let the pipeline settle, then write
  task automatic write_repo(input logic [REPO_W-1:0] v);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_repo = v;
    n_cfg++;
  endtask

  task automatic issue(input op_t op, input logic [REPO_W-1:0] hrepo,
                       input logic [IDX_W-1:0] hidx, input logic [GEN_W-1:0] hgen,
                       input logic typed, input slot_result_t want);
    slot_result_t pred;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
    end
    burst_left--;
    start             <= 1'b1;
    operation         <= op;
    handle_repo       <= hrepo;
    handle_index      <= hidx;
    handle_generation <= hgen;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = predict_slot(op, hrepo, hidx, hgen);
    pending_q.insert(pending_q.size(), typed ? want : pred);
    n_items++;
    case (pred.status)
      ST_OK: begin
        if (op == OP_ALLOC) begin
          n_alloc_ok++;
          live_q.insert(live_q.size(), pred.idx);
        end else begin
          n_release_ok++;
          for (int k = 0; k < live_q.size(); k++) begin
            if (live_q[k] == pred.idx) begin
              live_q.delete(k);
              break;
            end
          end
        end
      end
      ST_FULL: n_full++;
      default: n_rejected++;
    endcase
  endtask

  // weighted mix of allocations, well-formed releases, stale or foreign handles and noise
  task automatic random_item(input int w_alloc, input int w_valid, input int w_stale,
                             input int w_repo, input int w_noise);
    int pick;
    int k;
    logic [IDX_W-1:0] ix;
    logic [GEN_W-1:0] g;
    pick = $urandom_range(0, w_alloc + w_valid + w_stale + w_repo + w_noise - 1);
    ix = '0;
    g  = '0;
    if (live_q.size() != 0) begin
      k  = $urandom_range(0, live_q.size() - 1);
      ix = live_q[k];
      g  = gen_tab[ix];
    end
    if (pick < w_alloc || (live_q.size() == 0 && pick < w_alloc + w_valid)) begin
      issue(OP_ALLOC, REPO_W'($urandom), IDX_W'($urandom), $urandom, 1'b0, '0);
    end else if (pick < w_alloc + w_valid) begin
      issue(OP_RELEASE, cur_repo, ix, g, 1'b0, '0);
    end else if (pick < w_alloc + w_valid + w_stale) begin
      if (live_q.size() == 0 || $urandom_range(0, 1) == 0) begin
        // previous generation of some used slot, freed or not
        ix = (next_fresh > 1) ? IDX_W'($urandom_range(1, next_fresh - 1)) : IDX_W'(1);
        g  = gen_tab[ix] - 1;
      end else begin
        g = g ^ (32'h1 << $urandom_range(0, 31));
      end
      issue(OP_RELEASE, cur_repo, ix, g, 1'b0, '0);
    end else if (pick < w_alloc + w_valid + w_stale + w_repo) begin
      issue(OP_RELEASE, cur_repo ^ REPO_W'($urandom_range(1, 255)), ix, g, 1'b0, '0);
    end else begin
      issue(OP_RELEASE, REPO_W'($urandom), IDX_W'($urandom), $urandom, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    if (!rst && done) begin
      got = {status, out_repo, out_index, out_generation};
      if (pending_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: status %0d repo %0d index %0d gen %h",
                   got.status, got.repo, got.idx, got.gen);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected status %0d repo %0d index %0d gen %h, got %0d %0d %0d %h",
                     want.status, want.repo, want.idx, want.gen,
                     got.status, got.repo, got.idx, got.gen);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no progress for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cur_repo = 8'd1;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      alive_tab[i] = 1'b0;
      gen_tab[i]   = 32'd1;
      free_stk[i]  = '0;
    end
    free_cnt = 0;
    next_fresh = 1;
    n_items = 0;
    n_alloc_ok = 0;
    n_release_ok = 0;
    n_rejected = 0;
    n_full = 0;
    n_cfg = 0;
    n_bad = 0;
    burst_left = 0;
    stall_cycles = 0;

    // directed: fresh slots, lifo reuse, each reason a handle is refused, repo extremes
    req_row(OP_ALLOC,   8'hFF, 10'h3FF, 32'hFFFFFFFF, 1'b1, ST_OK,      8'd1, 10'd1, 32'd1);
    req_row(OP_ALLOC,   8'h00, 10'h000, 32'h0,        1'b1, ST_OK,      8'd1, 10'd2, 32'd1);
    req_row(OP_RELEASE, 8'd1,  10'd1,   32'd1,        1'b1, ST_OK,      8'd1, 10'd1, 32'd2);
    req_row(OP_RELEASE, 8'd1,  10'd1,   32'd1,        1'b1, ST_INVALID, 8'd0, 10'd0, 32'd0);
    req_row(OP_ALLOC,   8'h00, 10'h000, 32'h0,        1'b1, ST_OK,      8'd1, 10'd1, 32'd2);
    req_row(OP_RELEASE, 8'd1,  10'd1,   32'd1,        1'b1, ST_INVALID, 8'd0, 10'd0, 32'd0);
    req_row(OP_RELEASE, 8'd2,  10'd1,   32'd2,        1'b1, ST_INVALID, 8'd0, 10'd0, 32'd0);
    req_row(OP_RELEASE, 8'd1,  10'd0,   32'd1,        1'b1, ST_INVALID, 8'd0, 10'd0, 32'd0);
    req_row(OP_RELEASE, 8'd1,  10'd3,   32'd1,        1'b1, ST_INVALID, 8'd0, 10'd0, 32'd0);
    req_row(OP_RELEASE, 8'hFF, 10'h3FF, 32'hFFFFFFFF, 1'b1, ST_INVALID, 8'd0, 10'd0, 32'd0);
    req_row(OP_RELEASE, 8'd0,  10'd0,   32'd0,        1'b1, ST_INVALID, 8'd0, 10'd0, 32'd0);
    req_row(OP_RELEASE, 8'd1,  10'd2,   32'd1,        1'b1, ST_OK,      8'd1, 10'd2, 32'd2);
    req_row(OP_RELEASE, 8'd1,  10'd1,   32'd2,        1'b1, ST_OK,      8'd1, 10'd1, 32'd3);
    req_row(OP_ALLOC,   8'h00, 10'h000, 32'h0,        1'b1, ST_OK,      8'd1, 10'd1, 32'd3);
    req_row(OP_ALLOC,   8'h00, 10'h000, 32'h0,        1'b1, ST_OK,      8'd1, 10'd2, 32'd2);
    req_row(OP_ALLOC,   8'h00, 10'h000, 32'h0,        1'b1, ST_OK,      8'd1, 10'd3, 32'd1);
    cfg_row(8'd0);
    req_row(OP_ALLOC,   8'h00, 10'h000, 32'h0,        1'b1, ST_OK,      8'd0, 10'd4, 32'd1);
    req_row(OP_RELEASE, 8'd0,  10'd4,   32'd1,        1'b1, ST_INVALID, 8'd0, 10'd0, 32'd0);
    cfg_row(8'd1);
    req_row(OP_RELEASE, 8'd1,  10'd4,   32'd1,        1'b1, ST_OK,      8'd1, 10'd4, 32'd2);
    cfg_row(8'hFF);
    req_row(OP_RELEASE, 8'hFF, 10'd3,   32'd1,        1'b1, ST_OK,      8'hFF, 10'd3, 32'd2);
    req_row(OP_ALLOC,   8'h5A, 10'h2A5, 32'hA5A55A5A, 1'b0, ST_OK,      8'd0, 10'd0, 32'd0);
    req_row(OP_RELEASE, 8'hFF, 10'd3,   32'd2,        1'b0, ST_OK,      8'd0, 10'd0, 32'd0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].is_cfg)
        write_repo(plan[n].cfg_val);
      else
        issue(plan[n].op, plan[n].hrepo, plan[n].hidx, plan[n].hgen,
              plan[n].typed, plan[n].want);
    end

    write_repo(REPO_W'($urandom_range(2, 254)));
    repeat (390) random_item(40, 35, 10, 5, 10);

    // zero repo: allocations pass with repo 0, every release is refused
    write_repo(8'd0);
    repeat (40) random_item(50, 30, 0, 0, 20);

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("%0d requests: %0d allocated, %0d released, %0d refused, %0d on a full table",
             n_items, n_alloc_ok, n_release_ok, n_rejected, n_full);
    $display("%0d repo_id writes including 0 and 255, %0d slots live at the end",
             n_cfg, live_q.size());
    if (n_bad == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/gsa_pkg.sv
rtl/gsa_free_stack.sv
rtl/generational_slot_allocator.sv
tb/tb_generational_slot_allocator.sv
